// ----- hdl/ttg_pkg.sv -----
// ttg_pkg: shared widths, codes, item layouts and ramp constants of the
// thermal throttle governor. No dependencies.
package ttg_pkg;

	localparam int TEMP_W      = 14;
	localparam int PWR_W       = 15;
	localparam int ALPHA_W     = 16;
	localparam int THR_W       = 16;
	localparam int VCNT_W      = 32;
	localparam int PEAK_W      = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 120;

	localparam int HISTORY_DEPTH_DEF = 64;

	// internal channel value width: holds temp, hotspot and power alike
	localparam int VAL_W  = 16;
	localparam int MUL_W  = 23;
	localparam int PROD_W = 2 * MUL_W;
	// ramp numerator width after the first multiply
	localparam int RMP_N_W = 22;

	localparam int EMA_ROUND = 32768;
	localparam int EMA_SHIFT = 16;
	localparam int THR_FULL  = 32768;
	localparam int THR_FLOOR = 3277;
	localparam int HYST      = 80;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOTSPOT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA     = 2'd3;

	localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST    = 14'sd1440;
	localparam logic signed [TEMP_W-1:0] HOTSPOT_LIMIT_RST = 14'sd1760;
	localparam logic [PWR_W-1:0]         POWER_LIMIT_RST   = 15'd4800;
	localparam logic [ALPHA_W-1:0]       EMA_ALPHA_RST     = 16'd6554;

	localparam int NCH = 3;
	localparam logic [1:0] CH_TEMP = 2'd0;
	localparam logic [1:0] CH_HOT  = 2'd1;
	localparam logic [1:0] CH_PWR  = 2'd2;
	localparam logic [1:0] CH_LAST = CH_PWR;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [MUL_W-1:0]  mul_op_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic [1:0]               pad;
		logic                     power_valid;
		logic [PWR_W-1:0]         power;
		logic                     hotspot_valid;
		logic signed [TEMP_W-1:0] hotspot;
		logic                     temp_valid;
		logic signed [TEMP_W-1:0] temp;
	} in_item_t;

	typedef struct packed {
		logic [PWR_W-1:0]         smoothed_power;
		logic signed [TEMP_W-1:0] smoothed_hotspot;
		logic signed [TEMP_W-1:0] smoothed_temp;
		logic [PEAK_W-1:0]        peak_temp;
		logic signed [TEMP_W-1:0] average_temp;
		logic [VCNT_W-1:0]        violation_total;
		logic                     violation_now;
		logic                     limit_breached;
		logic [THR_W-1:0]         throttle;
	} out_item_t;

	// Ramp reduction: floor((d*mulc + bias) * recip >> shift), exact for
	// d in 1..span. Numerator and divisor were pre-scaled by a power of two.
	typedef struct packed {
		logic [9:0]  span;
		logic [13:0] mulc;
		logic [5:0]  bias;
		logic [20:0] recip;
		logic [4:0]  shift;
	} rmp_const_t;

	function automatic rmp_const_t rmp_const(input logic [1:0] ch);
		rmp_const_t c;
		case (ch)
			CH_TEMP: c = '{span: 10'd240, mulc: 14'd7168, bias: 6'd37,
				recip: 21'd1789570, shift: 5'd27};
			CH_HOT:  c = '{span: 10'd160, mulc: 14'd4608, bias: 6'd12,
				recip: 21'd1342178, shift: 5'd25};
			CH_PWR:  c = '{span: 10'd480, mulc: 14'd2560, bias: 6'd37,
				recip: 21'd1789570, shift: 5'd27};
			default: c = '{span: 10'd480, mulc: 14'd2560, bias: 6'd37,
				recip: 21'd1789570, shift: 5'd27};
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/ttg_ram.sv -----
// ttg_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttg_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/ttg_mul.sv -----
// ttg_mul: shared signed multiplier with registered product.
// Depends on ttg_pkg for operand and product types.
module ttg_mul (
	input  logic           clk,
	input  ttg_pkg::mul_op_t a,
	input  ttg_pkg::mul_op_t b,
	output ttg_pkg::prod_t   p_q
);
	import ttg_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= prod_t'(a) * prod_t'(b);
	end

endmodule

// ----- hdl/ttg_div.sv -----
// ttg_div: serial restoring divider, one quotient bit per cycle, signed
// dividend, unsigned divisor, quotient truncated toward zero. No dependencies.
module ttg_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    busy,
	output logic signed [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic             busy_q;

	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;
	logic             fits;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
		fits    = !trial[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ----- hdl/thermal_throttle_governor_core.sv -----
// thermal_throttle_governor_core: top level of the thermal throttle governor.
// Depends on ttg_pkg, ttg_ram, ttg_mul and ttg_div.
//
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+--------------------------------------
// s_       | in  | s_tvalid/s_tready | s_tdata sample fields, s_tuser kind
// m_       | out | m_tvalid/m_tready | m_tdata one result per transaction
// cfg_     | in  | cfg_we            | cfg_index register, cfg_data value
//
// A sample's result waits in ST_DIV until the serial mean divider, one
// quotient bit per cycle, is done; the divider runs while the EMA and ramp
// steps share one multiplier beside it. A clear transaction goes from accept
// straight to ST_FIN. s_tready is high only while idle; a finished result
// waits in the output register, so one new transaction may be taken while
// m_tready is low. Reset is asynchronous, active low; the history RAM is not
// cleared, a fill count guards reads of unwritten slots.
module thermal_throttle_governor_core #(
	parameter int HISTORY_DEPTH = ttg_pkg::HISTORY_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [13:0] temp, [14] temp_valid, [28:15] hotspot, [29] hotspot_valid,
	// [44:30] power, [45] power_valid, [47:46] zero
	input  logic [ttg_pkg::IN_TDATA_W-1:0] s_tdata,
	// [0] kind: 0 sample, 1 clear
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// [15:0] throttle, [16] limit_breached, [17] violation_now,
	// [49:18] violation_total, [63:50] average_temp, [76:64] peak_temp,
	// [90:77] smoothed_temp, [104:91] smoothed_hotspot, [119:105] smoothed_power
	output logic [ttg_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [ttg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ttg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ttg_pkg::*;

	localparam int HEAD_W = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = TEMP_W + $clog2(HISTORY_DEPTH);
	localparam int RING_W = TEMP_W + 1;
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(HISTORY_DEPTH - 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_UPD      = 4'd1;
	localparam logic [3:0] ST_EMA_MUL  = 4'd2;
	localparam logic [3:0] ST_EMA_ADD  = 4'd3;
	localparam logic [3:0] ST_RMP_MUL1 = 4'd4;
	localparam logic [3:0] ST_RMP_MUL2 = 4'd5;
	localparam logic [3:0] ST_RMP_ACC  = 4'd6;
	localparam logic [3:0] ST_DIV      = 4'd7;
	localparam logic [3:0] ST_FIN      = 4'd8;

	logic [3:0] state_q;

	// configuration
	logic signed [TEMP_W-1:0] temp_limit_q;
	logic signed [TEMP_W-1:0] hotspot_limit_q;
	logic [PWR_W-1:0]         power_limit_q;
	logic [ALPHA_W-1:0]       alpha_q;

	// captured sample and running statistics
	val_t             x_q [NCH];
	logic [NCH-1:0]   xv_q;
	val_t             ema_q [NCH];
	logic [NCH-1:0]   evb_q;
	logic             first_q;
	logic [1:0]       ch_q;
	logic [HEAD_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [PEAK_W-1:0] peak_q;
	logic [VCNT_W-1:0] vcnt_q;
	logic             breach_q;
	logic             viol_q;
	logic [THR_W-2:0] red_max_q;

	logic      m_tvalid_q;
	out_item_t out_q;

	in_item_t in_item;
	logic     in_fire;

	assign in_item  = in_item_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// ---------------------------------------------------------------
	// history ring: read of the head slot is always in flight, so the
	// evicted entry is on ring_rd in the cycle after accept
	// ---------------------------------------------------------------
	logic [RING_W-1:0] ring_rd;
	logic [RING_W-1:0] ring_wd;

	assign ring_wd = {xv_q[CH_TEMP], x_q[CH_TEMP][TEMP_W-1:0]};

	ttg_ram #(
		.WIDTH(RING_W),
		.DEPTH(HISTORY_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (state_q == ST_UPD),
		.waddr(head_q),
		.wdata(ring_wd),
		.raddr(head_q),
		.rdata(ring_rd)
	);

	// ---------------------------------------------------------------
	// ring bookkeeping, violation and breach for the update cycle
	// ---------------------------------------------------------------
	logic                    full_w;
	logic                    evict_w;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] sum_nxt;
	logic [FILL_W-1:0]       cnt_nxt;
	logic                    viol_w;
	logic                    hyst_ok;
	logic                    breach_nxt;
	val_t                    tl_w;
	val_t                    hl_w;
	val_t                    pl_w;

	always_comb begin
		tl_w    = val_t'(temp_limit_q);
		hl_w    = val_t'(hotspot_limit_q);
		pl_w    = val_t'(power_limit_q);
		full_w  = (fill_q == FILL_FULL);
		evict_w = full_w && ring_rd[TEMP_W];
		old_ext = evict_w ? SUM_W'($signed(ring_rd[TEMP_W-1:0])) : '0;
		new_ext = xv_q[CH_TEMP] ? SUM_W'(x_q[CH_TEMP]) : '0;
		sum_nxt = sum_q - old_ext + new_ext;
		cnt_nxt = cnt_q - FILL_W'(evict_w) + FILL_W'(xv_q[CH_TEMP]);
		viol_w  = (xv_q[CH_TEMP] && x_q[CH_TEMP] > tl_w)
			|| (xv_q[CH_HOT] && x_q[CH_HOT] > hl_w)
			|| (xv_q[CH_PWR] && x_q[CH_PWR] > pl_w);
		hyst_ok = xv_q[CH_TEMP] && xv_q[CH_HOT]
			&& x_q[CH_TEMP] < tl_w - val_t'(HYST)
			&& x_q[CH_HOT] < hl_w - val_t'(HYST);
		breach_nxt = (breach_q || viol_w) && !hyst_ok;
	end

	// ---------------------------------------------------------------
	// mean of valid ring entries: divider runs beside the EMA/ramp work
	// ---------------------------------------------------------------
	logic                    div_busy;
	logic signed [SUM_W-1:0] div_quo;

	ttg_div #(
		.NUM_W(SUM_W),
		.DEN_W(FILL_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_UPD),
		.num   (sum_nxt),
		.den   (cnt_nxt),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	// ---------------------------------------------------------------
	// shared multiplier and its operand selection
	// ---------------------------------------------------------------
	mul_op_t mul_a;
	mul_op_t mul_b;
	prod_t   prod_q;

	ttg_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(prod_q)
	);

	rmp_const_t              rc;
	val_t                    lim_sel;
	logic signed [VAL_W:0]   ema_diff;
	prod_t                   ema_inc;
	val_t                    ema_new;
	logic signed [VAL_W+1:0] rmp_d;
	logic signed [VAL_W+1:0] span_ext;
	logic                    rmp_pos;
	logic [9:0]              rmp_dc;
	logic [RMP_N_W-1:0]      rmp_n;
	prod_t                   red_full;
	logic [THR_W-2:0]        red_w;
	logic                    ch_last;

	always_comb begin
		rc = rmp_const(ch_q);
		case (ch_q)
			CH_TEMP: lim_sel = tl_w;
			CH_HOT:  lim_sel = hl_w;
			CH_PWR:  lim_sel = pl_w;
			default: lim_sel = pl_w;
		endcase
		ch_last  = (ch_q == CH_LAST);
		ema_diff = (VAL_W+1)'(x_q[ch_q]) - (VAL_W+1)'(ema_q[ch_q]);
		// round half up, floor divide by 65536
		ema_inc  = (prod_q + prod_t'(EMA_ROUND)) >>> EMA_SHIFT;
		ema_new  = ema_q[ch_q] + val_t'(ema_inc[VAL_W-1:0]);
		span_ext = (VAL_W+2)'(rc.span);
		rmp_d    = (VAL_W+2)'(ema_q[ch_q]) - (VAL_W+2)'(lim_sel) + span_ext;
		rmp_pos  = rmp_d > 0;
		rmp_dc   = (rmp_d > span_ext) ? rc.span : rmp_d[9:0];
		rmp_n    = prod_q[RMP_N_W-1:0] + RMP_N_W'(rc.bias);
		red_full = prod_q >>> rc.shift;
		red_w    = red_full[THR_W-2:0];

		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EMA_MUL: begin
				mul_a = mul_op_t'({1'b0, alpha_q});
				mul_b = mul_op_t'(ema_diff);
			end
			ST_RMP_MUL1: begin
				mul_a = mul_op_t'(rmp_dc);
				mul_b = mul_op_t'(rc.mulc);
			end
			ST_RMP_MUL2: begin
				mul_a = mul_op_t'(rmp_n);
				mul_b = mul_op_t'(rc.recip);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// result assembly
	// ---------------------------------------------------------------
	out_item_t        res_w;
	logic [THR_W-1:0] thr_raw;
	logic             have_samples;
	logic             out_load;

	always_comb begin
		have_samples = (fill_q != '0);
		thr_raw      = THR_W'(THR_FULL) - THR_W'(red_max_q);
		if (!have_samples) begin
			res_w.throttle = THR_W'(THR_FULL);
		end else if (thr_raw < THR_W'(THR_FLOOR)) begin
			res_w.throttle = THR_W'(THR_FLOOR);
		end else begin
			res_w.throttle = thr_raw;
		end
		res_w.limit_breached  = breach_q;
		res_w.violation_now   = viol_q;
		res_w.violation_total = vcnt_q;
		res_w.average_temp    = (cnt_q != '0) ? div_quo[TEMP_W-1:0] : '0;
		res_w.peak_temp       = peak_q;
		res_w.smoothed_temp   = (have_samples && evb_q[CH_TEMP])
			? ema_q[CH_TEMP][TEMP_W-1:0] : '0;
		res_w.smoothed_hotspot = (have_samples && evb_q[CH_HOT])
			? ema_q[CH_HOT][TEMP_W-1:0] : '0;
		res_w.smoothed_power  = (have_samples && evb_q[CH_PWR])
			? ema_q[CH_PWR][PWR_W-1:0] : '0;
		out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	end

	// ---------------------------------------------------------------
	// sequencer and control state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			temp_limit_q    <= TEMP_LIMIT_RST;
			hotspot_limit_q <= HOTSPOT_LIMIT_RST;
			power_limit_q   <= POWER_LIMIT_RST;
			alpha_q         <= EMA_ALPHA_RST;
			head_q          <= '0;
			fill_q          <= '0;
			cnt_q           <= '0;
			sum_q           <= '0;
			peak_q          <= '0;
			vcnt_q          <= '0;
			breach_q        <= 1'b0;
			viol_q          <= 1'b0;
			evb_q           <= '1;
			first_q         <= 1'b0;
			ch_q            <= CH_TEMP;
			m_tvalid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TEMP_LIMIT:    temp_limit_q    <= cfg_data[TEMP_W-1:0];
					REG_HOTSPOT_LIMIT: hotspot_limit_q <= cfg_data[TEMP_W-1:0];
					REG_POWER_LIMIT:   power_limit_q   <= cfg_data[PWR_W-1:0];
					REG_EMA_ALPHA:     alpha_q         <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						viol_q <= 1'b0;
						if (s_tuser) begin
							// clear transaction: statistics back to reset
							head_q   <= '0;
							fill_q   <= '0;
							cnt_q    <= '0;
							sum_q    <= '0;
							peak_q   <= '0;
							vcnt_q   <= '0;
							breach_q <= 1'b0;
							evb_q    <= '1;
							state_q  <= ST_FIN;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					head_q  <= (head_q == HEAD_LAST) ? '0 : head_q + HEAD_W'(1);
					fill_q  <= full_w ? fill_q : fill_q + FILL_W'(1);
					sum_q   <= sum_nxt;
					cnt_q   <= cnt_nxt;
					if (xv_q[CH_TEMP] && x_q[CH_TEMP] > val_t'(peak_q)) begin
						peak_q <= x_q[CH_TEMP][PEAK_W-1:0];
					end
					if (viol_w && vcnt_q != '1) begin
						vcnt_q <= vcnt_q + VCNT_W'(1);
					end
					viol_q   <= viol_w;
					breach_q <= breach_nxt;
					first_q  <= (fill_q == '0);
					evb_q    <= (fill_q == '0) ? xv_q : (evb_q & xv_q);
					ch_q     <= CH_TEMP;
					state_q  <= ST_EMA_MUL;
				end
				ST_EMA_MUL: begin
					if (!first_q && evb_q[ch_q]) begin
						state_q <= ST_EMA_ADD;
					end else if (ch_last) begin
						ch_q    <= CH_TEMP;
						state_q <= ST_RMP_MUL1;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				ST_EMA_ADD: begin
					if (ch_last) begin
						ch_q    <= CH_TEMP;
						state_q <= ST_RMP_MUL1;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_EMA_MUL;
					end
				end
				ST_RMP_MUL1: begin
					if (evb_q[ch_q] && rmp_pos) begin
						state_q <= ST_RMP_MUL2;
					end else if (ch_last) begin
						state_q <= ST_DIV;
					end else begin
						ch_q <= ch_q + 2'd1;
					end
				end
				ST_RMP_MUL2: begin
					state_q <= ST_RMP_ACC;
				end
				ST_RMP_ACC: begin
					if (ch_last) begin
						state_q <= ST_DIV;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_RMP_MUL1;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q[CH_TEMP] <= val_t'(in_item.temp);
			x_q[CH_HOT]  <= val_t'(in_item.hotspot);
			x_q[CH_PWR]  <= val_t'(in_item.power);
			xv_q         <= {in_item.power_valid, in_item.hotspot_valid,
				in_item.temp_valid};
			red_max_q    <= '0;
		end
		// first sample since clear loads the averages as they are
		if (state_q == ST_UPD && fill_q == '0) begin
			ema_q[CH_TEMP] <= x_q[CH_TEMP];
			ema_q[CH_HOT]  <= x_q[CH_HOT];
			ema_q[CH_PWR]  <= x_q[CH_PWR];
		end
		if (state_q == ST_EMA_ADD) begin
			ema_q[ch_q] <= ema_new;
		end
		if (state_q == ST_RMP_ACC && red_w > red_max_q) begin
			red_max_q <= red_w;
		end
		if (out_load) begin
			out_q <= res_w;
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL && cnt_q <= fill_q)
		else $error("ring fill or valid count out of range");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser) |=> (fill_q == '0 && vcnt_q == '0 && !breach_q))
		else $error("clear transaction left statistics behind");

	a_div_finished: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !div_busy)
		else $error("result assembled while the mean divider is busy");

	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_q.throttle >= THR_W'(THR_FLOOR)
			&& out_q.throttle <= THR_W'(THR_FULL)))
		else $error("throttle out of range");
`endif

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for thermal_throttle_governor_core.
// Depends on ttg_pkg and the core; predicts every readout with its own
// bit-exact governor model and checks each result transaction against it.
module tb_top;
	import ttg_pkg::*;

	localparam int HIST_DEPTH  = 64;
	localparam int STALL_LIMIT = 1000;  // cycles with no transaction at all
	localparam int MAX_PRINTS  = 200;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// in_item_t from bit 0: temp, temp_valid, hotspot, hotspot_valid,
	// power, power_valid, two zero pad bits
	logic [IN_TDATA_W-1:0] s_tdata;
	// [0] kind: 0 sample, 1 clear
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	// out_item_t from bit 0: throttle, limit_breached, violation_now,
	// violation_total, average_temp, peak_temp, smoothed temp/hotspot/power
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	thermal_throttle_governor_core #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Governor state mirror: ring of {valid, temp}, running valid sum/count,
	// peak, saturating violation count, breach flag, EMAs and their valid bits.
	logic [14:0] hist_mem [HIST_DEPTH];
	int hist_wr, hist_cnt, tsum, tcnt, tpeak;
	logic [31:0] vcount;
	bit breached;
	int avg_t, avg_h, avg_p;
	logic [2:0] avg_ok;   // bit 0 temp, bit 1 hotspot, bit 2 power

	// register mirror
	int lim_t, lim_h, lim_p, alpha_w;

	// operating points the random readings wander around
	int op_t, op_h, op_p;

	out_item_t readout_q[$];
	int src_idle_pct, snk_idle_pct;
	int errors, n_samples, n_clears, n_checked, n_writes, n_settings, quiet_cycles;
	bit live;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_history();
		hist_wr  = 0;
		hist_cnt = 0;
		tsum     = 0;
		tcnt     = 0;
		tpeak    = 0;
		vcount   = '0;
		breached = 1'b0;
		avg_t    = 0;
		avg_h    = 0;
		avg_p    = 0;
		avg_ok   = 3'b111;
	endfunction

	// ema + floor((alpha * (x - ema) + 32768) / 65536)
	function automatic int ema_next(int cur, int x);
		longint prod;
		prod = longint'(alpha_w) * longint'(x - cur) + 64'sd32768;
		return cur + int'(prod >>> 16);
	endfunction

	// one linear ramp: reduction k/10 of full scale over span below the limit
	function automatic int ramp_cap(int cur, int ema, int lim, int span, int k);
		int d, red;
		d = ema - (lim - span);
		if (d <= 0)
			return cur;
		if (d > span)
			d = span;
		red = (d * k * 32768 + span * 5) / (span * 10);
		return (32768 - red < cur) ? 32768 - red : cur;
	endfunction

	function automatic out_item_t compute_readout(bit clr, in_item_t s);
		out_item_t r;
		bit hit;
		int thr, mean, st, sh, sp, t, h, p, old_t;
		logic [2:0] vb;
		hit  = 1'b0;
		thr  = 32768;
		mean = 0;
		st   = 0;
		sh   = 0;
		sp   = 0;
		if (clr) begin
			clear_history();
		end else begin
			t  = $signed(s.temp);
			h  = $signed(s.hotspot);
			p  = s.power;
			vb = {s.power_valid, s.hotspot_valid, s.temp_valid};
			// full ring: evict oldest entry from the running sum
			if (hist_cnt >= HIST_DEPTH) begin
				if (hist_mem[hist_wr][14]) begin
					old_t = $signed(hist_mem[hist_wr][13:0]);
					tsum -= old_t;
					tcnt--;
				end
			end else begin
				hist_cnt++;
			end
			hist_mem[hist_wr] = {s.temp_valid, s.temp};
			if (s.temp_valid) begin
				tsum += t;
				tcnt++;
			end
			hist_wr = (hist_wr + 1) % HIST_DEPTH;
			if (s.temp_valid && t > tpeak)
				tpeak = t;
			// first sample since clear loads the averages outright
			if (hist_cnt == 1) begin
				avg_t  = t;
				avg_h  = h;
				avg_p  = p;
				avg_ok = vb;
			end else begin
				avg_ok &= vb;
				if (avg_ok[0]) avg_t = ema_next(avg_t, t);
				if (avg_ok[1]) avg_h = ema_next(avg_h, h);
				if (avg_ok[2]) avg_p = ema_next(avg_p, p);
			end
			if (s.temp_valid && t > lim_t) hit = 1'b1;
			if (s.hotspot_valid && h > lim_h) hit = 1'b1;
			if (s.power_valid && p > lim_p) hit = 1'b1;
			if (hit) begin
				if (vcount != 32'hFFFF_FFFF)
					vcount++;
				breached = 1'b1;
			end
			// hysteresis release, 5 degrees below both temperature limits
			if (breached && s.temp_valid && t < lim_t - 80 &&
					s.hotspot_valid && h < lim_h - 80)
				breached = 1'b0;
		end
		if (hist_cnt > 0) begin
			if (avg_ok[0]) begin
				st  = avg_t;
				thr = ramp_cap(thr, avg_t, lim_t, 240, 7);
			end
			if (avg_ok[1]) begin
				sh  = avg_h;
				thr = ramp_cap(thr, avg_h, lim_h, 160, 9);
			end
			if (avg_ok[2]) begin
				sp  = avg_p;
				thr = ramp_cap(thr, avg_p, lim_p, 480, 5);
			end
			if (thr < 3277)
				thr = 3277;
		end
		if (tcnt > 0)
			mean = tsum / tcnt;   // truncates toward zero
		r.throttle         = thr[15:0];
		r.limit_breached   = breached;
		r.violation_now    = hit;
		r.violation_total  = vcount;
		r.average_temp     = mean[13:0];
		r.peak_temp        = tpeak[12:0];
		r.smoothed_temp    = st[13:0];
		r.smoothed_hotspot = sh[13:0];
		r.smoothed_power   = sp[14:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int clamp_int(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// park the operating points in and around the ramp regions
	function automatic void recenter_ops();
		op_t = clamp_int(lim_t - 300 + int'($urandom_range(0, 500)), -8192, 8191);
		op_h = clamp_int(lim_h - 200 + int'($urandom_range(0, 350)), -8192, 8191);
		op_p = clamp_int(lim_p - 600 + int'($urandom_range(0, 900)), 0, 32767);
	endfunction

	function automatic in_item_t sample_of(int t, bit tv, int h, bit hv, int p, bit pv);
		in_item_t s;
		s               = '0;
		s.temp          = t[13:0];
		s.temp_valid    = tv;
		s.hotspot       = h[13:0];
		s.hotspot_valid = hv;
		s.power         = p[14:0];
		s.power_valid   = pv;
		return s;
	endfunction

	function automatic in_item_t random_sample();
		in_item_t s;
		op_t = clamp_int(op_t + int'($urandom_range(0, 48)) - 24, -8192, 8191);
		op_h = clamp_int(op_h + int'($urandom_range(0, 48)) - 24, -8192, 8191);
		op_p = clamp_int(op_p + int'($urandom_range(0, 96)) - 48, 0, 32767);
		s = sample_of(op_t, $urandom_range(0, 199) != 0, op_h, $urandom_range(0, 199) != 0,
			op_p, $urandom_range(0, 199) != 0);
		// occasional glitch reading anywhere in range
		if ($urandom_range(0, 24) == 0) begin
			s.temp    = 14'($urandom);
			s.hotspot = 14'($urandom);
			s.power   = 15'($urandom);
		end
		return s;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t: mismatch, %s", $time, what);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
				n_checked, name, got, want));
	endtask

	// result side: random stall, then compare every accepted transaction
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

	always @(posedge clk) begin : result_check
		out_item_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (readout_q.size() == 0) begin
				report_mismatch("result transaction with nothing outstanding");
			end else begin
				want = readout_q.pop_front();
				n_checked++;
				check_field("throttle", got.throttle, want.throttle);
				check_field("limit_breached", got.limit_breached, want.limit_breached);
				check_field("violation_now", got.violation_now, want.violation_now);
				check_field("violation_total", got.violation_total, want.violation_total);
				check_field("average_temp", got.average_temp, want.average_temp);
				check_field("peak_temp", got.peak_temp, want.peak_temp);
				check_field("smoothed_temp", got.smoothed_temp, want.smoothed_temp);
				check_field("smoothed_hotspot", got.smoothed_hotspot, want.smoothed_hotspot);
				check_field("smoothed_power", got.smoothed_power, want.smoothed_power);
			end
		end
	end

	// watchdog: any transaction or register write restarts the count
	always @(posedge clk) begin
		if (live) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d cycles without a transaction", quiet_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// one input transaction; expectation is computed at the accepting edge
	task automatic send_item(bit clr, in_item_t it);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= clr;
		s_tdata  <= it;
		do @(posedge clk); while (!s_tready);
		readout_q.push_back(compute_readout(clr, it));
		if (clr)
			n_clears++;
		else
			n_samples++;
	endtask

	// clear carries junk in the sample fields; the block must ignore it
	task automatic send_clear();
		logic [IN_TDATA_W-1:0] raw;
		in_item_t it;
		raw    = {16'($urandom), $urandom};
		it     = raw;
		it.pad = '0;
		send_item(1'b1, it);
	endtask

	// stop sending and let every outstanding result drain
	task automatic wait_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		@(posedge clk);
		case (idx)
			REG_TEMP_LIMIT:    lim_t = $signed(word[13:0]);
			REG_HOTSPOT_LIMIT: lim_h = $signed(word[13:0]);
			REG_POWER_LIMIT:   lim_p = word[14:0];
			REG_EMA_ALPHA:     alpha_w = word;
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// all four registers, only once the block is idle; unused high bits get junk
	task automatic set_limits(int t, int h, int p, int a);
		logic [CFG_DATA_W-1:0] w;
		wait_quiet();
		w = 16'($urandom);
		w[13:0] = t[13:0];
		write_reg(REG_TEMP_LIMIT, w);
		w = 16'($urandom);
		w[13:0] = h[13:0];
		write_reg(REG_HOTSPOT_LIMIT, w);
		w = 16'($urandom);
		w[14:0] = p[14:0];
		write_reg(REG_POWER_LIMIT, w);
		write_reg(REG_EMA_ALPHA, a[15:0]);
		n_settings++;
		recenter_ops();
	endtask

	// drifting sample streams, rare clears so the ring wraps, rare full drains
	task automatic run_random(int n_items, int src_pct, int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 89) == 0) begin
				send_clear();
				recenter_ops();
			end else begin
				if ($urandom_range(0, 249) == 0)
					wait_quiet();
				send_item(1'b0, random_sample());
			end
		end
	endtask

	// ---------------------------------------------------------------- tests

	// reset limits: temp 1440, hotspot 1760, power 4800
	task automatic test_directed_cases();
		send_clear();                                              // nothing seen yet
		send_item(1'b0, sample_of(8191, 1, -8192, 1, 32767, 1));  // first sample loads EMAs
		send_item(1'b0, sample_of(-8192, 1, 8191, 1, 0, 1));
		send_item(1'b0, sample_of(0, 0, 0, 0, 0, 0));             // all readings invalid
		send_clear();
		send_item(1'b0, sample_of(100, 0, 1000, 1, 4000, 1));     // first sample, temp invalid
		send_item(1'b0, sample_of(-3, 1, 900, 1, 4000, 1));
		send_item(1'b0, sample_of(-4, 1, 900, 1, 4000, 1));       // mean -3.5 -> -3
		send_clear();
		send_item(1'b0, sample_of(1440, 1, 1760, 1, 4800, 1));    // exactly at limits
		send_item(1'b0, sample_of(1441, 1, 1000, 1, 1000, 1));    // temp over: breach
		send_item(1'b0, sample_of(1360, 1, 1000, 1, 1000, 1));    // at hysteresis edge
		send_item(1'b0, sample_of(1359, 1, 1000, 0, 1000, 1));    // hotspot invalid, holds
		send_clear();
		send_item(1'b0, sample_of(1200, 1, 1761, 1, 1000, 1));    // hotspot over
		send_item(1'b0, sample_of(1359, 1, 1679, 1, 1000, 1));    // both below: release
		send_item(1'b0, sample_of(1000, 1, 1000, 1, 4801, 1));    // power over, released same item
		send_item(1'b0, sample_of(1000, 1, 8191, 0, 32767, 0));   // invalid never violates
		send_item(1'b0, sample_of(1000, 1, 1000, 1, 1000, 1));
	endtask

	task automatic test_limit_extremes();
		set_limits(-8192, -8192, 0, 1);
		send_clear();
		run_random(80, 11, 54);
		set_limits(8191, 8191, 32767, 65535);
		send_clear();
		run_random(80, 11, 54);
		set_limits(int'($urandom_range(0, 3200)) - 200, int'($urandom_range(0, 3200)) - 200,
			$urandom_range(0, 9000), $urandom_range(1, 65535));
		run_random(80, 11, 54);
	endtask

	task automatic test_random_traffic();
		set_limits(1440, 1760, 4800, 6554);
		run_random(380, 11, 54);
		set_limits(int'($urandom_range(800, 2000)), int'($urandom_range(1000, 2400)),
			$urandom_range(500, 8000), $urandom_range(1, 65535));
		run_random(380, 54, 11);
		set_limits(int'($urandom_range(800, 2000)), int'($urandom_range(1000, 2400)),
			$urandom_range(500, 8000), $urandom_range(1000, 20000));
		run_random(380, 0, 0);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tuser      = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		live         = 1'b0;
		errors       = 0;
		n_samples    = 0;
		n_clears     = 0;
		n_checked    = 0;
		n_writes     = 0;
		n_settings   = 0;
		quiet_cycles = 0;
		src_idle_pct = 11;
		snk_idle_pct = 54;
		clear_history();
		lim_t   = 1440;
		lim_h   = 1760;
		lim_p   = 4800;
		alpha_w = 6554;
		recenter_ops();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		live = 1'b1;

		test_directed_cases();
		test_limit_extremes();
		test_random_traffic();

		// drain, then watch a while for stray results
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d samples and %0d clears, %0d results checked, %0d mismatches",
			n_samples, n_clears, n_checked, errors);
		$display("%0d register writes over %0d limit settings, ring wrap, both stall patterns",
			n_writes, n_settings);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ttg_pkg.sv
hdl/ttg_ram.sv
hdl/ttg_mul.sv
hdl/ttg_div.sv
hdl/thermal_throttle_governor_core.sv
tb/tb_top.sv
